// ----- hdl/e2c_pkg.sv -----
// shared types, constants and tables for the epoch seconds to calendar block
// no dependencies

package e2c_pkg;

   localparam int SECS_W  = 32;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int DAYS_W  = 16;
   localparam int MEND_W  = 9;
   localparam int PROD_W  = 64;
   localparam int RSP_W   = 40;

   localparam logic [YEAR_W-1:0]  EPOCH_YEAR   = 12'd1970;
   localparam logic [DAYS_W-1:0]  COMMON_DAYS  = 16'd365;
   localparam logic [DAYS_W-1:0]  LEAP_DAYS    = 16'd366;
   localparam logic [MONTH_W-1:0] LAST_MONTH   = 4'd11;
   localparam logic [SECS_W-1:0]  RECIP_60     = 32'h8888_8889;
   localparam logic [SECS_W-1:0]  RECIP_3      = 32'hAAAA_AAAB;
   localparam int                 SHIFT_60     = 37;
   localparam int                 SHIFT_24     = 33;

   localparam logic [MEND_W-1:0] MONTH_END_COMMON [12] = '{
      9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };
   localparam logic [MEND_W-1:0] MONTH_END_LEAP [12] = '{
      9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
      9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL60,
      OP_SEC,
      OP_MIN,
      OP_MUL3,
      OP_HOUR,
      OP_YEAR,
      OP_MONTH,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic year_done;
      logic month_done;
   } dp_status_type;

   function automatic logic [MEND_W-1:0] month_end(input logic leap,
                                                   input logic [MONTH_W-1:0] idx);
      logic [MEND_W-1:0] value;
      if (idx > LAST_MONTH) begin
         value = '0;
      end else if (leap) begin
         value = MONTH_END_LEAP[idx];
      end else begin
         value = MONTH_END_COMMON[idx];
      end
      return value;
   endfunction

endpackage

// ----- hdl/e2c_datapath.sv -----
// datapath: shared reciprocal multiplier, year and month step units, result register
// depends on e2c_pkg

module e2c_datapath (
   input  logic                          clock,
   input  logic [e2c_pkg::SECS_W-1:0]    epoch_seconds,
   input  e2c_pkg::dp_cmd_type           cmd,
   output e2c_pkg::dp_status_type        status,
   output logic [e2c_pkg::RSP_W-1:0]     result
);

   logic [e2c_pkg::SECS_W-1:0]  work_ff, work_in;
   logic [e2c_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [e2c_pkg::SEC_W-1:0]   sec_ff, sec_in;
   logic [e2c_pkg::MIN_W-1:0]   min_ff, min_in;
   logic [e2c_pkg::HOUR_W-1:0]  hour_ff, hour_in;
   logic [e2c_pkg::DAYS_W-1:0]  days_ff, days_in;
   logic [e2c_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [e2c_pkg::MONTH_W-1:0] mon_ff, mon_in;
   logic [e2c_pkg::RSP_W-1:0]   result_ff, result_in;

   logic [e2c_pkg::SECS_W-1:0]  mul_a;
   logic [e2c_pkg::SECS_W-1:0]  mul_b;
   logic [e2c_pkg::SECS_W-1:0]  q60;
   logic [e2c_pkg::SECS_W-1:0]  q24;
   logic [e2c_pkg::SECS_W-1:0]  rem60;
   logic [e2c_pkg::SECS_W-1:0]  rem24;
   logic                        leap;
   logic [e2c_pkg::DAYS_W-1:0]  year_len;
   logic [e2c_pkg::DAYS_W-1:0]  mend_cur;
   logic [e2c_pkg::DAYS_W-1:0]  mend_prev;
   logic                        month_adv;
   logic [e2c_pkg::DAYS_W-1:0]  day_of_month;
   logic [e2c_pkg::MONTH_W-1:0] month_out;
   logic [e2c_pkg::DAY_W-1:0]   day_out;

   // one multiplier, constant chosen per step
   assign mul_a = (cmd.op == e2c_pkg::OP_MUL3) ? (work_ff >> 3) : work_ff;
   assign mul_b = (cmd.op == e2c_pkg::OP_MUL3) ? e2c_pkg::RECIP_3 : e2c_pkg::RECIP_60;

   assign q60   = e2c_pkg::SECS_W'(prod_ff >> e2c_pkg::SHIFT_60);
   assign q24   = e2c_pkg::SECS_W'(prod_ff >> e2c_pkg::SHIFT_24);
   assign rem60 = work_ff - ((q60 << 6) - (q60 << 2));
   assign rem24 = work_ff - ((q24 << 4) + (q24 << 3));

   assign leap      = (year_ff[1:0] == 2'b00);
   assign year_len  = leap ? e2c_pkg::LEAP_DAYS : e2c_pkg::COMMON_DAYS;
   assign mend_cur  = e2c_pkg::DAYS_W'(e2c_pkg::month_end(leap, mon_ff));
   assign mend_prev = (mon_ff == '0) ? '0 :
                      e2c_pkg::DAYS_W'(e2c_pkg::month_end(leap, mon_ff - 4'd1));
   assign month_adv = (mon_ff < e2c_pkg::LAST_MONTH) && (days_ff >= mend_cur);

   assign status.year_done  = (days_ff < year_len);
   assign status.month_done = !month_adv;

   assign day_of_month = days_ff - mend_prev + 16'd1;
   assign month_out    = mon_ff + 4'd1;
   assign day_out      = day_of_month[e2c_pkg::DAY_W-1:0];

   always_comb begin
      work_in   = work_ff;
      prod_in   = prod_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      mon_in    = mon_ff;
      result_in = result_ff;
      unique case (cmd.op) inside
         e2c_pkg::OP_LOAD: begin
            work_in = epoch_seconds;
         end
         e2c_pkg::OP_MUL60, e2c_pkg::OP_MUL3: begin
            prod_in = e2c_pkg::PROD_W'(mul_a) * e2c_pkg::PROD_W'(mul_b);
         end
         e2c_pkg::OP_SEC: begin
            sec_in  = rem60[e2c_pkg::SEC_W-1:0];
            work_in = q60;
         end
         e2c_pkg::OP_MIN: begin
            min_in  = rem60[e2c_pkg::MIN_W-1:0];
            work_in = q60;
         end
         e2c_pkg::OP_HOUR: begin
            hour_in = rem24[e2c_pkg::HOUR_W-1:0];
            days_in = q24[e2c_pkg::DAYS_W-1:0];
            year_in = e2c_pkg::EPOCH_YEAR;
            mon_in  = '0;
         end
         e2c_pkg::OP_YEAR: begin
            if (!status.year_done) begin
               days_in = days_ff - year_len;
               year_in = year_ff + 12'd1;
            end
         end
         e2c_pkg::OP_MONTH: begin
            if (month_adv) begin
               mon_in = mon_ff + 4'd1;
            end
         end
         e2c_pkg::OP_OUT: begin
            // second, minute, hour, day, month, year from the top bits down
            result_in = {2'b00, sec_ff, min_ff, hour_ff, day_out, month_out, year_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      prod_ff   <= prod_in;
      sec_ff    <= sec_in;
      min_ff    <= min_in;
      hour_ff   <= hour_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mon_ff    <= mon_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ----- hdl/e2c_ctrl.sv -----
// controller state machine: sequences the datapath steps and runs the handshakes
// depends on e2c_pkg

module e2c_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  e2c_pkg::dp_status_type  status,
   output e2c_pkg::dp_cmd_type     cmd
);

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_MUL1   = 10'b00_0000_0010,
      ST_DIV1   = 10'b00_0000_0100,
      ST_MUL2   = 10'b00_0000_1000,
      ST_DIV2   = 10'b00_0001_0000,
      ST_MUL3   = 10'b00_0010_0000,
      ST_DIV3   = 10'b00_0100_0000,
      ST_YEAR   = 10'b00_1000_0000,
      ST_MONTH  = 10'b01_0000_0000,
      ST_FINISH = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_load;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign out_load   = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      cmd.op   = e2c_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = e2c_pkg::OP_LOAD;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.op   = e2c_pkg::OP_MUL60;
            state_in = ST_DIV1;
         end
         ST_DIV1: begin
            cmd.op   = e2c_pkg::OP_SEC;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.op   = e2c_pkg::OP_MUL60;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            cmd.op   = e2c_pkg::OP_MIN;
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.op   = e2c_pkg::OP_MUL3;
            state_in = ST_DIV3;
         end
         ST_DIV3: begin
            cmd.op   = e2c_pkg::OP_HOUR;
            state_in = ST_YEAR;
         end
         ST_YEAR: begin
            cmd.op = e2c_pkg::OP_YEAR;
            if (status.year_done) begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            cmd.op = e2c_pkg::OP_MONTH;
            if (status.month_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               cmd.op   = e2c_pkg::OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ----- hdl/epoch_seconds_to_calendar_top.sv -----
// top level: epoch seconds to calendar date and time
// run time grows with the years after 1970 and the months passed, which are stepped through one by one
// a new item is taken only once the last has reached the output register; the year loop dominates
// a finished result waits in the output register while the next item is taken
// reset (synchronous, active high) returns the controller to idle and drops rsp_tvalid
// depends on e2c_pkg, e2c_ctrl, e2c_datapath

module epoch_seconds_to_calendar_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [e2c_pkg::SECS_W-1:0]  req_tdata,   // epoch_seconds
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [e2c_pkg::RSP_W-1:0]   rsp_tdata    // year, month, day, hour, minute, second
);

   e2c_pkg::dp_cmd_type    cmd;
   e2c_pkg::dp_status_type status;

   e2c_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   e2c_datapath u_datapath (
      .clock         (clock),
      .epoch_seconds (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .result        (rsp_tdata)
   );

endmodule
